>>> rtl/core/tffp_pkg.sv
// tffp_pkg: shared constants and types for the tagged float frame parser
// frame marker bytes, phase codes and the frame tracker status struct
// no dependencies
package tffp_pkg;

    // frame marker characters
    localparam logic [7:0] CHR_D = 8'h44;
    localparam logic [7:0] CHR_A = 8'h41;
    localparam logic [7:0] CHR_T = 8'h54;
    localparam logic [7:0] CHR_E = 8'h45;
    localparam logic [7:0] CHR_N = 8'h4E;

    // frame phase codes
    localparam logic [3:0] PH_HUNT = 4'd0;
    localparam logic [3:0] PH_HDR1 = 4'd1;
    localparam logic [3:0] PH_HDR2 = 4'd2;
    localparam logic [3:0] PH_HDR3 = 4'd3;
    localparam logic [3:0] PH_TYPE = 4'd4;
    localparam logic [3:0] PH_VAL0 = 4'd5;
    localparam logic [3:0] PH_VAL1 = 4'd6;
    localparam logic [3:0] PH_VAL2 = 4'd7;
    localparam logic [3:0] PH_VAL3 = 4'd8;
    localparam logic [3:0] PH_TRL1 = 4'd9;
    localparam logic [3:0] PH_TRL2 = 4'd10;
    localparam logic [3:0] PH_TRL3 = 4'd11;

    // sample kinds
    localparam logic KIND_POS = 1'b0;
    localparam logic KIND_VEL = 1'b1;

    // configuration register indexes
    localparam logic CFG_POS_CODE = 1'b0;
    localparam logic CFG_VEL_CODE = 1'b1;

    // status from the frame tracker to the top level
    typedef struct packed {
        logic        hit;
        logic        kind;
        logic [31:0] bits;
        logic [3:0]  phase;
    } t_frame_stat;

endpackage

>>> rtl/core/tffp_frame.sv
// tffp_frame: frame phase tracker with type and value capture
// flags a finished frame with a known type in the cycle its last byte transfers
// depends on tffp_pkg
module tffp_frame
    import tffp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_pos_code,
    input  logic [7:0]  i_vel_code,
    output t_frame_stat o_stat
);

    logic [3:0]  r_phase;
    logic [3:0]  n_phase;
    logic [7:0]  r_type;
    logic [31:0] r_val;
    logic        w_pos_hit;
    logic        w_vel_hit;

    // next phase for the transferred byte
    always_comb begin
        n_phase = PH_HUNT;
        case (r_phase)
            PH_HDR1: n_phase = (i_rx_byte == CHR_A) ? PH_HDR2 : PH_HUNT;
            PH_HDR2: n_phase = (i_rx_byte == CHR_T) ? PH_HDR3 : PH_HUNT;
            PH_HDR3: n_phase = (i_rx_byte == CHR_A) ? PH_TYPE : PH_HUNT;
            PH_TYPE: n_phase = PH_VAL0;
            PH_VAL0: n_phase = PH_VAL1;
            PH_VAL1: n_phase = PH_VAL2;
            PH_VAL2: n_phase = PH_VAL3;
            PH_VAL3: n_phase = PH_TRL1;
            PH_TRL1: n_phase = (i_rx_byte == CHR_E) ? PH_TRL2 : PH_HUNT;
            PH_TRL2: n_phase = (i_rx_byte == CHR_N) ? PH_TRL3 : PH_HUNT;
            PH_TRL3: n_phase = PH_HUNT;
            default: n_phase = (i_rx_byte == CHR_D) ? PH_HDR1 : PH_HUNT;
        endcase
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
        end else if (i_acc) begin
            r_phase <= n_phase;
        end
    end

    // type byte and little-endian value capture, shifted in from the top
    always_ff @(posedge i_clk) begin
        if (i_acc && r_phase == PH_TYPE) begin
            r_type <= i_rx_byte;
        end
        if (i_acc && r_phase >= PH_VAL0 && r_phase <= PH_VAL3) begin
            r_val <= {i_rx_byte, r_val[31:8]};
        end
    end

    // final trailer byte with a known type; position wins on equal codes
    assign w_pos_hit = (r_type == i_pos_code);
    assign w_vel_hit = (r_type == i_vel_code);

    always_comb begin
        o_stat.hit   = i_acc && (r_phase == PH_TRL3) && (i_rx_byte == CHR_D)
                       && (w_pos_hit || w_vel_hit);
        o_stat.kind  = w_pos_hit ? KIND_POS : KIND_VEL;
        o_stat.bits  = r_val;
        o_stat.phase = r_phase;
    end

endmodule

>>> rtl/core/tagged_float_frame_parser.sv
// tagged_float_frame_parser: hunts D,A,T,A, takes type plus 4 value bytes, checks E,N,D
// a sample is valid on o_valid in the cycle after its final trailer byte transfers
// throughput: 1 byte per cycle while o_ready is high, set by the single phase register update per byte
// the result register frees in the cycle it transfers, so input stalls only on output stall
// reset (synchronous, active low): phase to hunting, no result pending, codes to 0 and 1
module tagged_float_frame_parser
    import tffp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_sample_kind,
    output logic [31:0] o_sample_bits,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]  r_pos_code;
    logic [7:0]  r_vel_code;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [31:0] r_out_bits;
    logic        w_in_acc;
    t_frame_stat w_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_code <= 8'd0;
            r_vel_code <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POS_CODE: r_pos_code <= i_cfg_data;
                CFG_VEL_CODE: r_vel_code <= i_cfg_data;
                default:      r_pos_code <= r_pos_code;
            endcase
        end
    end

    // input transfer whenever the result register is free or draining
    assign o_ready  = !r_out_valid || i_ready;
    assign w_in_acc = i_valid && o_ready;

    tffp_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_in_acc),
        .i_rx_byte  (i_rx_byte),
        .i_pos_code (r_pos_code),
        .i_vel_code (r_vel_code),
        .o_stat     (w_stat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.hit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.hit) begin
            r_out_kind <= w_stat.kind;
            r_out_bits <= w_stat.bits;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sample_kind = r_out_kind;
    assign o_sample_bits = r_out_bits;

`ifndef SYNTHESIS
    // phase never leaves the defined range
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.phase <= PH_TRL3)
        else $error("frame phase out of range");

    // a result is only produced on a transferred final trailer byte
    a_hit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.hit |-> (w_in_acc && w_stat.phase == PH_TRL3))
        else $error("result without final trailer byte");

    // phase holds when no byte transfers
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(w_stat.phase))
        else $error("phase moved without a transfer");

    // a pending result is never overwritten before it transfers
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_stat.hit)
        else $error("pending result overwritten");
`endif

endmodule

>>> verif/tagged_float_frame_parser_tb.sv
`timescale 1ns / 1ps
// tagged_float_frame_parser_tb: self-checking bench for the tagged float frame parser
// feeds byte streams of whole, broken and noise frames with random gaps and output stalls
// depends on tffp_pkg and tagged_float_frame_parser
module tagged_float_frame_parser_tb;
    import tffp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 40;
    localparam int EXP_DEPTH    = 64;

    typedef struct packed {
        logic        kind;
        logic [31:0] bits;
    } t_sample;

    // one directed byte; known marks a sample that is read straight off the row
    typedef struct packed {
        logic [7:0]  rx;
        logic        known;
        logic        kind;
        logic [31:0] bits;
    } t_probe_row;

    localparam t_probe_row PROBE_ROWS [29] = '{
        // position frame, type 0 at reset, payload all ones
        '{CHR_D, 1'b0, KIND_POS, 32'h0}, '{CHR_A, 1'b0, KIND_POS, 32'h0},
        '{CHR_T, 1'b0, KIND_POS, 32'h0}, '{CHR_A, 1'b0, KIND_POS, 32'h0},
        '{8'h00, 1'b0, KIND_POS, 32'h0}, '{8'hFF, 1'b0, KIND_POS, 32'h0},
        '{8'hFF, 1'b0, KIND_POS, 32'h0}, '{8'hFF, 1'b0, KIND_POS, 32'h0},
        '{8'hFF, 1'b0, KIND_POS, 32'h0}, '{CHR_E, 1'b0, KIND_POS, 32'h0},
        '{CHR_N, 1'b0, KIND_POS, 32'h0}, '{CHR_D, 1'b1, KIND_POS, 32'hFFFF_FFFF},
        // doubled header start must not open a frame
        '{CHR_D, 1'b0, KIND_POS, 32'h0}, '{CHR_D, 1'b0, KIND_POS, 32'h0},
        '{CHR_A, 1'b0, KIND_POS, 32'h0}, '{CHR_T, 1'b0, KIND_POS, 32'h0},
        '{CHR_A, 1'b0, KIND_POS, 32'h0},
        // velocity frame, type 1 at reset, payload all zeros
        '{CHR_D, 1'b0, KIND_POS, 32'h0}, '{CHR_A, 1'b0, KIND_POS, 32'h0},
        '{CHR_T, 1'b0, KIND_POS, 32'h0}, '{CHR_A, 1'b0, KIND_POS, 32'h0},
        '{8'h01, 1'b0, KIND_POS, 32'h0}, '{8'h00, 1'b0, KIND_POS, 32'h0},
        '{8'h00, 1'b0, KIND_POS, 32'h0}, '{8'h00, 1'b0, KIND_POS, 32'h0},
        '{8'h00, 1'b0, KIND_POS, 32'h0}, '{CHR_E, 1'b0, KIND_POS, 32'h0},
        '{CHR_N, 1'b0, KIND_POS, 32'h0}, '{CHR_D, 1'b1, KIND_VEL, 32'h0000_0000}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [7:0]  i_rx_byte  = 8'h00;
    logic        i_ready    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = CFG_POS_CODE;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        o_ready;
    logic        o_valid;
    logic        o_sample_kind;
    logic [31:0] o_sample_bits;

    // local copy of the deframer state and the type codes
    logic [3:0]  trk_phase;
    logic [7:0]  trk_type;
    logic [31:0] trk_value;
    logic [7:0]  pos_code;
    logic [7:0]  vel_code;

    // expected samples, oldest at the read count
    t_sample     exp_fifo [EXP_DEPTH];
    int          exp_wr        = 0;
    int          exp_rd        = 0;
    t_sample     want_sample;
    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          bytes_fed     = 0;
    int          hold_requests = 0;
    logic        calm          = 1'b0;

    tagged_float_frame_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_sample_kind (o_sample_kind),
        .o_sample_bits (o_sample_bits),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // append one expected sample
    task automatic sample_put(input t_sample s);
        exp_fifo[exp_wr % EXP_DEPTH] = s;
        exp_wr++;
    endtask

    // remove and return the oldest expected sample
    function automatic t_sample sample_take();
        t_sample s;
        s = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        return s;
    endfunction

    // advance the local deframer by one byte, return 1 when a sample comes out
    function automatic bit deframe(input logic [7:0] b, output t_sample s);
        bit hit;
        hit = 1'b0;
        s   = '0;
        case (trk_phase)
            PH_HDR1: trk_phase = (b == CHR_A) ? PH_HDR2 : PH_HUNT;
            PH_HDR2: trk_phase = (b == CHR_T) ? PH_HDR3 : PH_HUNT;
            PH_HDR3: trk_phase = (b == CHR_A) ? PH_TYPE : PH_HUNT;
            PH_TYPE: begin
                trk_type  = b;
                trk_phase = PH_VAL0;
            end
            PH_VAL0, PH_VAL1, PH_VAL2, PH_VAL3: begin
                // little endian, newest byte enters at the top
                trk_value = {b, trk_value[31:8]};
                trk_phase = trk_phase + 4'd1;
            end
            PH_TRL1: trk_phase = (b == CHR_E) ? PH_TRL2 : PH_HUNT;
            PH_TRL2: trk_phase = (b == CHR_N) ? PH_TRL3 : PH_HUNT;
            PH_TRL3: begin
                trk_phase = PH_HUNT;
                // position wins when both codes are equal
                if (b == CHR_D && trk_type == pos_code) begin
                    hit    = 1'b1;
                    s.kind = KIND_POS;
                    s.bits = trk_value;
                end else if (b == CHR_D && trk_type == vel_code) begin
                    hit    = 1'b1;
                    s.kind = KIND_VEL;
                    s.bits = trk_value;
                end
            end
            // hunting, unused phases fall back here too
            default: trk_phase = (b == CHR_D) ? PH_HDR1 : PH_HUNT;
        endcase
        return hit;
    endfunction

    // input side: one byte transfer, at times with a random gap in front
    task automatic transfer_byte(input logic [7:0] b);
        if (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        t_sample s;
        transfer_byte(b);
        bytes_fed++;
        if (deframe(b, s))
            sample_put(s);
    endtask

    // mostly whole frames, some corrupted at one byte and maybe cut short there
    task automatic feed_frame();
        logic [7:0] frame [12];
        int roll;
        int cut;
        int kill;
        frame = '{CHR_D, CHR_A, CHR_T, CHR_A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  CHR_E, CHR_N, CHR_D};
        roll = $urandom_range(99);
        if (roll < 40)
            frame[4] = pos_code;
        else if (roll < 80)
            frame[4] = vel_code;
        else
            frame[4] = 8'($urandom_range(255));
        roll = $urandom_range(9);
        for (int i = 5; i < 9; i++)
            frame[i] = (roll == 0) ? 8'hFF : (roll == 1) ? 8'h00 : 8'($urandom_range(255));
        cut = 12;
        if ($urandom_range(99) < 18) begin
            kill        = $urandom_range(11);
            frame[kill] = 8'($urandom_range(255));
            if ($urandom_range(1) == 1)
                cut = kill + 1;
        end
        for (int i = 0; i < cut; i++)
            feed_byte(frame[i]);
    endtask

    task automatic run_phase(input int items);
        int start;
        start = bytes_fed;
        while (bytes_fed - start < items) begin
            if ($urandom_range(99) < 80) begin
                feed_frame();
            end else begin
                repeat ($urandom_range(6, 1))
                    feed_byte(($urandom_range(3) == 0) ? CHR_D : 8'($urandom_range(255)));
            end
        end
    endtask

    // stop sending and let every expected sample come out
    task automatic settle();
        i_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_codes(input logic [7:0] pos_value, input logic [7:0] vel_value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_POS_CODE;
        i_cfg_data <= pos_value;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_VEL_CODE;
        i_cfg_data <= vel_value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pos_code = pos_value;
        vel_code = vel_value;
    endtask

    // output side: random stalls, long hold-off on request
    initial begin : rx_side
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    // compare each sample transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected sample", o_sample_bits, 32'h0);
            end else begin
                want_sample = sample_take();
                if (o_sample_kind !== want_sample.kind)
                    report_mismatch("sample_kind", 32'(o_sample_kind), 32'(want_sample.kind));
                if (o_sample_bits !== want_sample.bits)
                    report_mismatch("sample_bits", o_sample_bits, want_sample.bits);
            end
        end
    end

    initial begin : stimulus
        t_sample s;
        t_sample row_s;
        bit      hit;
        trk_phase = PH_HUNT;
        trk_type  = 8'h00;
        trk_value = 32'h0;
        pos_code  = 8'h00;
        vel_code  = 8'h01;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset codes
        for (int r = 0; r < 29; r++) begin
            transfer_byte(PROBE_ROWS[r].rx);
            hit = deframe(PROBE_ROWS[r].rx, s);
            if (PROBE_ROWS[r].known) begin
                row_s.kind = PROBE_ROWS[r].kind;
                row_s.bits = PROBE_ROWS[r].bits;
                sample_put(row_s);
            end else if (hit) begin
                sample_put(s);
            end
        end
        settle();

        // reset codes, receiver holds off while frames keep coming
        hold_requests++;
        run_phase(PHASE_ITEMS);
        settle();

        set_codes(8'hFF, 8'h00);
        run_phase(PHASE_ITEMS);
        settle();

        // equal codes, no idling on either side
        set_codes(8'h07, 8'h07);
        calm = 1'b1;
        run_phase(PHASE_ITEMS);
        settle();
        calm = 1'b0;

        set_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
        run_phase(PHASE_ITEMS);
        settle();

        set_codes(8'h00, 8'hFF);
        run_phase(PHASE_ITEMS);
        settle();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tffp_pkg.sv
rtl/core/tffp_frame.sv
rtl/core/tagged_float_frame_parser.sv
verif/tagged_float_frame_parser_tb.sv
